@@ hdl/color_class_lookup_table_macros.svh @@
// Assertion helpers for the color class table.
// Each use stands on a line of its own and carries its own label and message.
`ifndef COLOR_CLASS_LOOKUP_TABLE_MACROS_SVH
`define COLOR_CLASS_LOOKUP_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCLT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CCLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cclt_pkg.sv @@
package cclt_pkg;

    // Field and register widths
    localparam int COORD_W   = 16;
    localparam int REG_W     = 17;
    localparam int CODE_W    = 8;
    localparam int NUM_W     = COORD_W + REG_W;
    localparam int DIV_STEPS = REG_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam int TABLE_ENTRIES_DEF = 65536;

    // Register reset values
    localparam logic [REG_W-1:0]  TABLE_WIDTH_RST     = REG_W'(256);
    localparam logic [REG_W-1:0]  TABLE_HEIGHT_RST    = REG_W'(256);
    localparam logic [REG_W-1:0]  TABLE_DEPTH_RST     = REG_W'(1);
    localparam logic [REG_W-1:0]  RANGE_RST           = REG_W'(256);
    localparam logic [CODE_W-1:0] OTHER_CODE_RST      = CODE_W'(0);
    localparam logic [CODE_W-1:0] BACKGROUND_CODE_RST = CODE_W'(1);

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_TABLE_WIDTH     = 3'd0;
    localparam logic [2:0] REG_TABLE_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_TABLE_DEPTH     = 3'd2;
    localparam logic [2:0] REG_FIRST_RANGE     = 3'd3;
    localparam logic [2:0] REG_SECOND_RANGE    = 3'd4;
    localparam logic [2:0] REG_THIRD_RANGE     = 3'd5;
    localparam logic [2:0] REG_OTHER_CODE      = 3'd6;
    localparam logic [2:0] REG_BACKGROUND_CODE = 3'd7;

    // Operation codes
    localparam logic [1:0] FUNC_CLASSIFY = 2'd0;
    localparam logic [1:0] FUNC_SET      = 2'd1;
    localparam logic [1:0] FUNC_MERGE    = 2'd2;
    localparam logic [1:0] FUNC_CLEAR    = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic               scaled;
        logic [COORD_W-1:0] coord_first;
        logic [COORD_W-1:0] coord_second;
        logic [COORD_W-1:0] coord_third;
        logic [CODE_W-1:0]  class_in;
    } item_t;

    typedef struct packed {
        logic [CODE_W-1:0] class_out;
        logic              status;
    } result_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_DIV,
        ST_MUL1,
        ST_SUM1,
        ST_MUL2,
        ST_SUM2,
        ST_READ,
        ST_MODIFY,
        ST_RESULT
    } state_t;

endpackage

@@ hdl/color_class_lookup_table.sv @@
// Channel   Direction  Payload              Handshake
// cfg       in         paddr/pwdata/prdata  psel, penable, pwrite, pready
// item      in         item (item_t)        item_valid / item_stall
// result    out        result (result_t)    result_valid / result_stall
//
// With scaling an item first runs through the 17-step divider (one per coordinate, run in
// parallel); without it, it goes straight to the address math. No new item is taken until idle.
// Address math uses two registered multiplies, then one read of the store and, for a set
// or an allowed merge, one write; an out-of-bounds item skips the store.
// After reset, and for a clear item, the store is swept one entry a cycle; a clear returns
// its result at sweep end. A pending result waits in pend_reg until the output reg is free.
module color_class_lookup_table #(
    parameter int TABLE_ENTRIES = cclt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cclt_pkg::ADDR_W-1:0]   paddr,
    input  logic [cclt_pkg::DATA_W-1:0]   pwdata,
    output logic [cclt_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  cclt_pkg::item_t               item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output cclt_pkg::result_t             result
);

`include "color_class_lookup_table_macros.svh"

    localparam int RW   = cclt_pkg::REG_W;
    localparam int CW   = cclt_pkg::CODE_W;
    localparam int AW   = $clog2(TABLE_ENTRIES);
    localparam int P1_W = 2 * RW;
    localparam int S1_W = P1_W + 1;
    localparam int P2_W = AW + RW;
    localparam int S2_W = P2_W + 1;
    localparam int DCW  = cclt_pkg::DIV_CNT_W;

    localparam logic [S1_W-1:0] ENTRIES_S1 = S1_W'(TABLE_ENTRIES);
    localparam logic [S2_W-1:0] ENTRIES_S2 = S2_W'(TABLE_ENTRIES);
    localparam logic [AW-1:0]   SWEEP_LAST = AW'(TABLE_ENTRIES - 1);
    localparam logic [DCW-1:0]  DIV_LAST   = DCW'(cclt_pkg::DIV_STEPS - 1);

    // Configuration registers
    logic [RW-1:0] table_width_reg;
    logic [RW-1:0] table_height_reg;
    logic [RW-1:0] table_depth_reg;
    logic [RW-1:0] first_range_reg;
    logic [RW-1:0] second_range_reg;
    logic [RW-1:0] third_range_reg;
    logic [CW-1:0] other_code_reg;
    logic [CW-1:0] background_code_reg;

    // Control
    cclt_pkg::state_t    state_reg, state_next;
    logic [AW-1:0]       sweep_cnt_reg;
    logic [CW-1:0]       fill_reg;
    logic                clear_reply_reg;
    logic [DCW-1:0]      div_cnt_reg;
    logic                result_valid_reg;
    cclt_pkg::div_ctrl_t div_ctrl;
    logic                accept;
    logic                res_load;
    logic                cfg_write;

    // Datapath
    cclt_pkg::item_t     item_reg;
    cclt_pkg::result_t   pend_reg;
    cclt_pkg::result_t   result_reg;
    logic [2:0]          bad_reg;
    logic [2:0]          bad_c;
    logic                err_reg;
    logic [P1_W-1:0]     prod1_reg;
    logic [RW-1:0]       iy_reg;
    logic [RW-1:0]       iz_reg;
    logic [AW-1:0]       a_reg;
    logic [P2_W-1:0]     prod2_reg;
    logic [AW-1:0]       addr_reg;
    logic [S1_W-1:0]     s1;
    logic [S2_W-1:0]     s2;
    logic [15:0]         coord_in [3];
    logic [15:0]         coord_held [3];
    logic [RW-1:0]       dim [3];
    logic [RW-1:0]       range_w [3];
    logic [RW-1:0]       quo [3];
    logic [RW-1:0]       idx_c [3];

    // Store port
    logic                ram_en;
    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [CW-1:0]       ram_wdata;
    logic [CW-1:0]       ram_rdata;
    logic                free_cur;
    logic                free_in;
    logic                write_ok;
    logic [CW-1:0]       new_class;

    assign accept    = item_valid && !item_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_width_reg     <= cclt_pkg::TABLE_WIDTH_RST;
            table_height_reg    <= cclt_pkg::TABLE_HEIGHT_RST;
            table_depth_reg     <= cclt_pkg::TABLE_DEPTH_RST;
            first_range_reg     <= cclt_pkg::RANGE_RST;
            second_range_reg    <= cclt_pkg::RANGE_RST;
            third_range_reg     <= cclt_pkg::RANGE_RST;
            other_code_reg      <= cclt_pkg::OTHER_CODE_RST;
            background_code_reg <= cclt_pkg::BACKGROUND_CODE_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                cclt_pkg::REG_TABLE_WIDTH:     table_width_reg     <= pwdata[RW-1:0];
                cclt_pkg::REG_TABLE_HEIGHT:    table_height_reg    <= pwdata[RW-1:0];
                cclt_pkg::REG_TABLE_DEPTH:     table_depth_reg     <= pwdata[RW-1:0];
                cclt_pkg::REG_FIRST_RANGE:     first_range_reg     <= pwdata[RW-1:0];
                cclt_pkg::REG_SECOND_RANGE:    second_range_reg    <= pwdata[RW-1:0];
                cclt_pkg::REG_THIRD_RANGE:     third_range_reg     <= pwdata[RW-1:0];
                cclt_pkg::REG_OTHER_CODE:      other_code_reg      <= pwdata[CW-1:0];
                cclt_pkg::REG_BACKGROUND_CODE: background_code_reg <= pwdata[CW-1:0];
                default:                       ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        case (paddr[4:2])
            cclt_pkg::REG_TABLE_WIDTH:     prdata = 32'(table_width_reg);
            cclt_pkg::REG_TABLE_HEIGHT:    prdata = 32'(table_height_reg);
            cclt_pkg::REG_TABLE_DEPTH:     prdata = 32'(table_depth_reg);
            cclt_pkg::REG_FIRST_RANGE:     prdata = 32'(first_range_reg);
            cclt_pkg::REG_SECOND_RANGE:    prdata = 32'(second_range_reg);
            cclt_pkg::REG_THIRD_RANGE:     prdata = 32'(third_range_reg);
            cclt_pkg::REG_OTHER_CODE:      prdata = 32'(other_code_reg);
            cclt_pkg::REG_BACKGROUND_CODE: prdata = 32'(background_code_reg);
            default:                       prdata = '0;
        endcase
    end

    // Per-coordinate lanes
    assign coord_in[0]   = item.coord_first;
    assign coord_in[1]   = item.coord_second;
    assign coord_in[2]   = item.coord_third;
    assign coord_held[0] = item_reg.coord_first;
    assign coord_held[1] = item_reg.coord_second;
    assign coord_held[2] = item_reg.coord_third;
    assign dim[0]        = table_width_reg;
    assign dim[1]        = table_height_reg;
    assign dim[2]        = table_depth_reg;
    assign range_w[0]    = first_range_reg;
    assign range_w[1]    = second_range_reg;
    assign range_w[2]    = third_range_reg;

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        // A scaled index stays below its dimension exactly when the coordinate is below range
        assign bad_c[l] = item.scaled
            ? ((RW'(coord_in[l]) >= range_w[l]) || (dim[l] == '0))
            : (RW'(coord_in[l]) >= dim[l]);

        assign idx_c[l] = item_reg.scaled ? quo[l] : RW'(coord_held[l]);

        cclt_div u_div (
            .clk  (clk),
            .ctrl (div_ctrl),
            .num  (cclt_pkg::NUM_W'(coord_in[l]) * cclt_pkg::NUM_W'(dim[l])),
            .den  (range_w[l]),
            .quo  (quo[l])
        );
    end

    // Address sums and bounds
    assign s1 = S1_W'(prod1_reg) + S1_W'(iy_reg);
    assign s2 = S2_W'(prod2_reg) + S2_W'(iz_reg);

    // Merge rule: overwrite a free entry with a class that is not free
    assign free_cur  = (ram_rdata == other_code_reg) || (ram_rdata == background_code_reg);
    assign free_in   = (item_reg.class_in == other_code_reg)
                    || (item_reg.class_in == background_code_reg);
    assign write_ok  = (item_reg.func == cclt_pkg::FUNC_SET)
                    || ((item_reg.func == cclt_pkg::FUNC_MERGE) && free_cur && !free_in);
    assign new_class = write_ok ? item_reg.class_in : ram_rdata;

    // Next state and store port
    always_comb
    begin
        state_next = state_reg;
        div_ctrl   = '0;
        ram_en     = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = addr_reg;
        ram_wdata  = item_reg.class_in;
        res_load   = 1'b0;
        case (state_reg)
            cclt_pkg::ST_SWEEP:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = sweep_cnt_reg;
                ram_wdata = fill_reg;
                if (sweep_cnt_reg == SWEEP_LAST)
                begin
                    state_next = clear_reply_reg ? cclt_pkg::ST_RESULT : cclt_pkg::ST_IDLE;
                end
            end
            cclt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    div_ctrl.load = 1'b1;
                    if (item.func == cclt_pkg::FUNC_CLEAR)
                    begin
                        state_next = cclt_pkg::ST_SWEEP;
                    end
                    else if (item.scaled)
                    begin
                        state_next = cclt_pkg::ST_DIV;
                    end
                    else
                    begin
                        state_next = cclt_pkg::ST_MUL1;
                    end
                end
            end
            cclt_pkg::ST_DIV:
            begin
                div_ctrl.step = 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = cclt_pkg::ST_MUL1;
                end
            end
            cclt_pkg::ST_MUL1: state_next = cclt_pkg::ST_SUM1;
            cclt_pkg::ST_SUM1: state_next = cclt_pkg::ST_MUL2;
            cclt_pkg::ST_MUL2: state_next = cclt_pkg::ST_SUM2;
            cclt_pkg::ST_SUM2:
            begin
                state_next = (err_reg || (s2 >= ENTRIES_S2))
                    ? cclt_pkg::ST_RESULT : cclt_pkg::ST_READ;
            end
            cclt_pkg::ST_READ:
            begin
                ram_en     = 1'b1;
                state_next = cclt_pkg::ST_MODIFY;
            end
            cclt_pkg::ST_MODIFY:
            begin
                ram_en     = write_ok;
                ram_we     = write_ok;
                state_next = cclt_pkg::ST_RESULT;
            end
            cclt_pkg::ST_RESULT:
            begin
                if (!(result_valid_reg && result_stall))
                begin
                    res_load   = 1'b1;
                    state_next = cclt_pkg::ST_IDLE;
                end
            end
            default: state_next = cclt_pkg::ST_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= cclt_pkg::ST_SWEEP;
            sweep_cnt_reg    <= '0;
            fill_reg         <= '0;
            clear_reply_reg  <= 1'b0;
            div_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == cclt_pkg::ST_SWEEP)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + AW'(1);
            end
            if (accept && (item.func == cclt_pkg::FUNC_CLEAR))
            begin
                sweep_cnt_reg   <= '0;
                fill_reg        <= other_code_reg;
                clear_reply_reg <= 1'b1;
            end
            if (state_reg == cclt_pkg::ST_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + DCW'(1);
            end
            else
            begin
                div_cnt_reg <= '0;
            end
            if (res_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
            bad_reg  <= bad_c;
        end
        case (state_reg)
            cclt_pkg::ST_SWEEP:
            begin
                pend_reg <= '{class_out: fill_reg, status: 1'b0};
            end
            cclt_pkg::ST_MUL1:
            begin
                prod1_reg <= P1_W'(idx_c[0]) * P1_W'(table_height_reg);
                iy_reg    <= idx_c[1];
                iz_reg    <= idx_c[2];
                err_reg   <= |bad_reg;
            end
            cclt_pkg::ST_SUM1:
            begin
                a_reg   <= s1[AW-1:0];
                err_reg <= err_reg || (s1 >= ENTRIES_S1);
            end
            cclt_pkg::ST_MUL2:
            begin
                prod2_reg <= P2_W'(a_reg) * P2_W'(table_depth_reg);
            end
            cclt_pkg::ST_SUM2:
            begin
                addr_reg <= s2[AW-1:0];
                err_reg  <= err_reg || (s2 >= ENTRIES_S2);
                pend_reg <= '{class_out: '0, status: 1'b1};
            end
            cclt_pkg::ST_MODIFY:
            begin
                pend_reg <= '{class_out: new_class, status: 1'b0};
            end
            default: ;
        endcase
        if (res_load)
        begin
            result_reg <= pend_reg;
        end
    end

    cclt_ram #(
        .WIDTH (CW),
        .DEPTH (TABLE_ENTRIES)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign item_stall   = (state_reg != cclt_pkg::ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Checks
    `CCLT_ASSERT_NEXT(a_accept_busy, accept, state_reg != cclt_pkg::ST_IDLE, "idle after accept")
    `CCLT_ASSERT_SAME(a_no_err_write, ram_we && (state_reg == cclt_pkg::ST_MODIFY), !err_reg, "store written on error")
    `CCLT_ASSERT_SAME(a_err_class, res_load && pend_reg.status, pend_reg.class_out == '0, "error result carries a class")

endmodule

@@ hdl/cclt_ram.sv @@
module cclt_ram #(
    parameter int WIDTH = cclt_pkg::CODE_W,
    parameter int DEPTH = cclt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

@@ hdl/cclt_div.sv @@
module cclt_div (
    input  logic                           clk,
    input  cclt_pkg::div_ctrl_t            ctrl,
    input  logic [cclt_pkg::NUM_W-1:0]     num,
    input  logic [cclt_pkg::REG_W-1:0]     den,
    output logic [cclt_pkg::REG_W-1:0]     quo
);

    localparam int W = cclt_pkg::REG_W;

    logic [W-1:0] rem_reg;
    logic [W-1:0] low_reg;
    logic [W-1:0] den_reg;
    logic [W-1:0] quo_reg;
    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         fits;

    // Bring down one numerator bit and try the subtract
    assign trial = {rem_reg, low_reg[W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    // Restoring division, one quotient bit per cycle; the quotient fits W bits when the coordinate is below its range
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg <= W'(num[cclt_pkg::NUM_W-1:W]);
            low_reg <= num[W-1:0];
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (ctrl.step)
        begin
            rem_reg <= fits ? diff[W-1:0] : trial[W-1:0];
            low_reg <= {low_reg[W-2:0], 1'b0};
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign quo = quo_reg;

endmodule
